// File: rtl/core/tbp_pkg.sv
// Shared types, register indexes and counter helpers for the tournament branch predictor.
// No dependencies; imported by tournament_branch_predictor.
package tbp_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // Register indexes of the configuration port
   localparam csr_index_type CSR_GLOBAL_HISTORY_BITS = 2'd0;
   localparam csr_index_type CSR_LOCAL_HISTORY_BITS  = 2'd1;
   localparam csr_index_type CSR_PC_INDEX_BITS       = 2'd2;

   localparam csr_data_type GLOBAL_HISTORY_BITS_RST = 4'd9;
   localparam csr_data_type LOCAL_HISTORY_BITS_RST  = 4'd10;
   localparam csr_data_type PC_INDEX_BITS_RST       = 4'd10;

   // Request opcodes
   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_TRAIN   = 1'b1;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_WEAK_NOT_TAKEN  = 2'd1;
   localparam ctr_type CHOOSER_WEAK_GLOBAL = 2'd1;
   localparam ctr_type CTR_MIN             = 2'd0;
   localparam ctr_type CTR_MAX             = 2'd3;

   // Saturating step of a 2-bit counter
   function automatic ctr_type sat_move(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != CTR_MIN) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/tournament_branch_predictor.sv
// Tournament branch predictor: local/global 2-bit counters with a 2-bit chooser.
// Depends on tbp_pkg (types, register indexes, saturating counter step).
//
// Throughput: one request per cycle while the result side takes transfers and no clearing
//   pass runs; a stalled result freezes the whole three-register pipeline (the memory read
//   ports set this).
// Reset: synchronous; after reset a clearing pass over 2**max(GLOBAL_HISTORY_MAX,
//   LOCAL_HISTORY_MAX, PC_INDEX_MAX) rows (4096 by default) loads the tables, req_ready low.
module tournament_branch_predictor #(
   parameter int GLOBAL_HISTORY_MAX = 12,
   parameter int LOCAL_HISTORY_MAX  = 12,
   parameter int PC_INDEX_MAX       = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [31:0]            req_pc,
   input  logic                   req_outcome,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_prediction,
   output logic                   rsp_chose_local,
   // configuration write port
   input  logic                   csr_write_en,
   input  tbp_pkg::csr_index_type csr_index,
   input  tbp_pkg::csr_data_type  csr_wdata
);
   import tbp_pkg::*;

   localparam int GH = GLOBAL_HISTORY_MAX;
   localparam int LH = LOCAL_HISTORY_MAX;
   localparam int PI = PC_INDEX_MAX;
   localparam int GL_MAX = (GH > LH) ? GH : LH;
   localparam int CLR_W  = (GL_MAX > PI) ? GL_MAX : PI;

   // ---------------------------------------------------------------------------------------
   // Tables. Chooser and global counters share the global-history index.
   // ---------------------------------------------------------------------------------------
   logic [LH-1:0] local_hist_mem [2**PI];
   ctr_type       local_ctr_mem  [2**LH];
   ctr_type       global_ctr_mem [2**GH];
   ctr_type       chooser_mem    [2**GH];

   // configuration
   csr_data_type ghist_bits_ff;
   csr_data_type lhist_bits_ff;
   csr_data_type pc_bits_ff;

   // clearing pass
   logic             clearing_ff;
   logic [CLR_W-1:0] clr_addr_ff;

   // global history register
   logic [GH-1:0] ghist_ff;
   logic [GH-1:0] ghist_in;

   // stage 1: local history read back
   logic          s1_valid_ff;
   logic          s1_train_ff;
   logic          s1_outcome_ff;
   logic [PI-1:0] s1_pidx_ff;
   logic [LH-1:0] hist_rd_ff;

   // stage 2: counter reads back
   logic          s2_valid_ff;
   logic          s2_train_ff;
   logic          s2_outcome_ff;
   logic [LH-1:0] s2_lidx_ff;
   logic [GH-1:0] s2_gidx_ff;
   ctr_type       lctr_rd_ff;
   ctr_type       gctr_rd_ff;
   ctr_type       ch_rd_ff;

   // bypass of the write that lands on the same edge as a read
   logic          hfwd_valid_ff;
   logic [PI-1:0] hfwd_idx_ff;
   logic [LH-1:0] hfwd_data_ff;
   logic          lfwd_valid_ff;
   logic [LH-1:0] lfwd_idx_ff;
   ctr_type       lfwd_data_ff;
   logic          gfwd_valid_ff;
   logic [GH-1:0] gfwd_idx_ff;
   ctr_type       gfwd_data_ff;
   ctr_type       cfwd_data_ff;

   // result register
   logic rsp_valid_ff;
   logic rsp_prediction_ff;
   logic rsp_chose_local_ff;

   // combinational
   logic          adv;
   logic          req_xfer;
   logic [GH-1:0] gmask;
   logic [LH-1:0] lmask;
   logic [PI-1:0] pmask;
   logic [PI-1:0] req_pidx;
   logic [LH-1:0] hist_cur;
   logic [LH-1:0] hist_in;
   logic [LH-1:0] s1_lidx;
   logic [GH-1:0] s1_gidx;
   logic          s1_write;
   ctr_type       lctr_cur;
   ctr_type       gctr_cur;
   ctr_type       ch_cur;
   ctr_type       lctr_in;
   ctr_type       gctr_in;
   ctr_type       ch_in;
   logic          local_pred;
   logic          global_pred;
   logic          use_local;
   logic          s2_write;

   // Whole pipe moves together; a held result freezes every stage and every read port.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clearing_ff;
   assign req_xfer  = req_valid && req_ready;

   // Index masks: a width of zero acts as one, a width above the maximum as the maximum.
   always_comb begin
      for (int i = 0; i < GH; i++) gmask[i] = (i == 0) || (i < int'(ghist_bits_ff));
      for (int i = 0; i < LH; i++) lmask[i] = (i == 0) || (i < int'(lhist_bits_ff));
      for (int i = 0; i < PI; i++) pmask[i] = (i == 0) || (i < int'(pc_bits_ff));
   end

   assign req_pidx = req_pc[PI-1:0] & pmask;

   // ---------------------------------------------------------------------------------------
   // Stage 1: pick up the local history (bypass a history written on the read edge),
   // form both counter indexes, shift the outcome into the histories.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      if (hfwd_valid_ff && (hfwd_idx_ff == s1_pidx_ff)) begin
         hist_cur = hfwd_data_ff;
      end else begin
         hist_cur = hist_rd_ff;
      end
      s1_lidx  = hist_cur & lmask;
      s1_gidx  = ghist_ff & gmask;
      hist_in  = ((hist_cur << 1) | LH'(s1_outcome_ff)) & lmask;
      ghist_in = ((ghist_ff << 1) | GH'(s1_outcome_ff)) & gmask;
      s1_write = s1_valid_ff && (s1_train_ff == OP_TRAIN);
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: counters (with bypass), prediction, chooser and counter updates.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      if (lfwd_valid_ff && (lfwd_idx_ff == s2_lidx_ff)) begin
         lctr_cur = lfwd_data_ff;
      end else begin
         lctr_cur = lctr_rd_ff;
      end
      if (gfwd_valid_ff && (gfwd_idx_ff == s2_gidx_ff)) begin
         gctr_cur = gfwd_data_ff;
         ch_cur   = cfwd_data_ff;
      end else begin
         gctr_cur = gctr_rd_ff;
         ch_cur   = ch_rd_ff;
      end
      local_pred  = lctr_cur[1];
      global_pred = gctr_cur[1];
      use_local   = ch_cur[1];
      lctr_in     = sat_move(lctr_cur, s2_outcome_ff);
      gctr_in     = sat_move(gctr_cur, s2_outcome_ff);
      // move the chooser only when the two sides disagree, toward the one that was right
      if (local_pred != global_pred) begin
         ch_in = sat_move(ch_cur, local_pred == s2_outcome_ff);
      end else begin
         ch_in = ch_cur;
      end
      s2_write = s2_valid_ff && (s2_train_ff == OP_TRAIN);
   end

   // ---------------------------------------------------------------------------------------
   // Tables: one write and one registered read each. The clearing pass owns the write port.
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         local_hist_mem[clr_addr_ff[PI-1:0]] <= '0;
      end else if (adv && s1_write) begin
         local_hist_mem[s1_pidx_ff] <= hist_in;
      end
      if (adv) begin
         hist_rd_ff <= local_hist_mem[req_pidx];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         local_ctr_mem[clr_addr_ff[LH-1:0]] <= CTR_WEAK_NOT_TAKEN;
      end else if (adv && s2_write) begin
         local_ctr_mem[s2_lidx_ff] <= lctr_in;
      end
      if (adv) begin
         lctr_rd_ff <= local_ctr_mem[s1_lidx];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         global_ctr_mem[clr_addr_ff[GH-1:0]] <= CTR_WEAK_NOT_TAKEN;
      end else if (adv && s2_write) begin
         global_ctr_mem[s2_gidx_ff] <= gctr_in;
      end
      if (adv) begin
         gctr_rd_ff <= global_ctr_mem[s1_gidx];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         chooser_mem[clr_addr_ff[GH-1:0]] <= CHOOSER_WEAK_GLOBAL;
      end else if (adv && s2_write) begin
         chooser_mem[s2_gidx_ff] <= ch_in;
      end
      if (adv) begin
         ch_rd_ff <= chooser_mem[s1_gidx];
      end
   end

   // ---------------------------------------------------------------------------------------
   // Control registers: configuration, clearing pass, pipeline valids, bypass valids.
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_bits_ff <= GLOBAL_HISTORY_BITS_RST;
         lhist_bits_ff <= LOCAL_HISTORY_BITS_RST;
         pc_bits_ff    <= PC_INDEX_BITS_RST;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         ghist_ff      <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hfwd_valid_ff <= 1'b0;
         lfwd_valid_ff <= 1'b0;
         gfwd_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_GLOBAL_HISTORY_BITS: ghist_bits_ff <= csr_wdata;
               CSR_LOCAL_HISTORY_BITS:  lhist_bits_ff <= csr_wdata;
               CSR_PC_INDEX_BITS:       pc_bits_ff    <= csr_wdata;
               default: ;  // drop writes to unused indexes
            endcase
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (&clr_addr_ff) clearing_ff <= 1'b0;
         end
         if (adv) begin
            s1_valid_ff   <= req_xfer;
            s2_valid_ff   <= s1_valid_ff;
            rsp_valid_ff  <= s2_valid_ff;
            hfwd_valid_ff <= s1_write;
            lfwd_valid_ff <= s2_write;
            gfwd_valid_ff <= s2_write;
            if (s1_write) ghist_ff <= ghist_in;
         end
      end
   end

   // Payload registers: advance with the pipe, no reset needed.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_train_ff        <= req_opcode;
         s1_outcome_ff      <= req_outcome;
         s1_pidx_ff         <= req_pidx;
         s2_train_ff        <= s1_train_ff;
         s2_outcome_ff      <= s1_outcome_ff;
         s2_lidx_ff         <= s1_lidx;
         s2_gidx_ff         <= s1_gidx;
         hfwd_idx_ff        <= s1_pidx_ff;
         hfwd_data_ff       <= hist_in;
         lfwd_idx_ff        <= s2_lidx_ff;
         lfwd_data_ff       <= lctr_in;
         gfwd_idx_ff        <= s2_gidx_ff;
         gfwd_data_ff       <= gctr_in;
         cfwd_data_ff       <= ch_in;
         rsp_prediction_ff  <= use_local ? local_pred : global_pred;
         rsp_chose_local_ff <= use_local;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prediction  = rsp_prediction_ff;
   assign rsp_chose_local = rsp_chose_local_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   a_clear_pipe_empty : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !s2_valid_ff && !hfwd_valid_ff && !lfwd_valid_ff)
      else $error("pipeline busy during table clearing pass");

   a_ghist_only_on_train : assert property (@(posedge clock) disable iff (reset)
      !(adv && s1_write) |=> $stable(ghist_ff))
      else $error("global history changed without a train transfer");

   a_rsp_from_stage2 : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff) && $past(adv))
      else $error("result appeared without an item in stage 2");

   a_bypass_pairs : assert property (@(posedge clock) disable iff (reset)
      lfwd_valid_ff == gfwd_valid_ff)
      else $error("counter bypass valids out of step");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the tournament branch predictor: random and directed
// predict/train traffic, checked against a local/global/chooser table model.
// Depends on tbp_pkg and rtl/core/tournament_branch_predictor.sv.
module testbench;
   import tbp_pkg::*;

   // Index widths of the block, also passed to the instance below, and the model table depth
   localparam int GHIST_MAX = 12;
   localparam int LHIST_MAX = 12;
   localparam int PCIDX_MAX = 12;
   localparam int DEPTH     = 4096;

   localparam csr_index_type CSR_UNUSED_INDEX = 2'd3;  // no register behind this index
   localparam ctr_type       CTR_TAKEN_MIN    = 2'd2;  // counter value that predicts taken

   localparam int HOT_COUNT  = 8;       // branches that recur in the random traffic
   localparam int HOLD_AFTER = 400;     // request transfers before the long result stall
   localparam int HOLD_LEN   = 120;     // cycles of the long result stall
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic        opcode;
      logic [31:0] pc;
      logic        outcome;
   } branch_req_type;

   typedef struct packed {
      logic prediction;
      logic chose_local;
   } branch_rsp_type;

   typedef enum int {LOOP_EXIT, NEVER_TAKEN, ALTERNATING, MOSTLY_TAKEN} outcome_pattern_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [31:0] req_pc;
   logic        req_outcome;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_prediction;
   logic        rsp_chose_local;
   logic        csr_write_en;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   // Predictor model state, kept in step with every request transfer
   ctr_type      glob_ctr   [DEPTH];
   ctr_type      loc_ctr    [DEPTH];
   ctr_type      choose_ctr [DEPTH];
   logic [11:0]  loc_hist   [DEPTH];
   logic [11:0]  glob_hist;
   csr_data_type cfg_ghist_bits;
   csr_data_type cfg_lhist_bits;
   csr_data_type cfg_pcidx_bits;

   branch_req_type pending_reqs[$];   // requests not yet put on the port
   branch_rsp_type awaited_dirs[$];   // predictions still owed by the block
   branch_req_type cur_req;
   branch_rsp_type seen_dir;
   logic        req_loaded;
   int          gap_left;
   int          burst_left;
   int          reqs_sent;
   int          mismatches;
   int          cycles;

   // Receiver stall state
   int   hold_left;
   logic hold_done;
   int   stall_mode;
   int   mode_left;
   logic ready_next;

   // Recurring branches: low PC bits, outcome pattern and loop position
   logic [11:0]         hot_low    [HOT_COUNT];
   outcome_pattern_type hot_kind   [HOT_COUNT];
   int                  hot_period [HOT_COUNT];
   int                  hot_pos    [HOT_COUNT];

   tournament_branch_predictor #(
      .GLOBAL_HISTORY_MAX (GHIST_MAX),
      .LOCAL_HISTORY_MAX  (LHIST_MAX),
      .PC_INDEX_MAX       (PCIDX_MAX)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pc          (req_pc),
      .req_outcome     (req_outcome),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prediction  (rsp_prediction),
      .rsp_chose_local (rsp_chose_local),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A width register of zero acts as one bit; above the maximum it clamps
   function automatic int eff_bits(input csr_data_type r, input int maxw);
      if (r == 4'd0) return 1;
      if (int'(r) > maxw) return maxw;
      return int'(r);
   endfunction

   function automatic ctr_type step_ctr(input ctr_type c, input logic up);
      if (up) return (c == CTR_MAX) ? c : c + 2'd1;
      return (c == CTR_MIN) ? c : c - 2'd1;
   endfunction

   // Look up the prediction in force for one request, then train the tables if asked
   function automatic branch_rsp_type resolve_branch(input branch_req_type r);
      int unsigned    gmask, lmask, pmask, pidx, lidx, gidx;
      logic           lpred, gpred;
      branch_rsp_type res;
      gmask = (1 << eff_bits(cfg_ghist_bits, GHIST_MAX)) - 1;
      lmask = (1 << eff_bits(cfg_lhist_bits, LHIST_MAX)) - 1;
      pmask = (1 << eff_bits(cfg_pcidx_bits, PCIDX_MAX)) - 1;
      pidx = r.pc & pmask;
      lidx = loc_hist[pidx] & lmask;
      gidx = glob_hist & gmask;
      lpred = loc_ctr[lidx] >= CTR_TAKEN_MIN;
      gpred = glob_ctr[gidx] >= CTR_TAKEN_MIN;
      res.chose_local = choose_ctr[gidx] >= CTR_TAKEN_MIN;
      res.prediction  = res.chose_local ? lpred : gpred;
      if (r.opcode == OP_TRAIN) begin
         // chooser only learns when the two sides disagree
         if (lpred != gpred) choose_ctr[gidx] = step_ctr(choose_ctr[gidx], lpred == r.outcome);
         loc_ctr[lidx]  = step_ctr(loc_ctr[lidx], r.outcome);
         glob_ctr[gidx] = step_ctr(glob_ctr[gidx], r.outcome);
         loc_hist[pidx] = 12'(((loc_hist[pidx] << 1) & lmask) | r.outcome);
         glob_hist      = 12'(((glob_hist << 1) & gmask) | r.outcome);
      end
      return res;
   endfunction

   task automatic queue_req(input logic op, input logic [31:0] pc, input logic dir);
      branch_req_type r;
      r.opcode  = op;
      r.pc      = pc;
      r.outcome = dir;
      pending_reqs.push_back(r);
   endtask

   task automatic reroll_hot(input int b);
      hot_low[b]    = 12'($urandom_range(0, DEPTH - 1));
      hot_kind[b]   = outcome_pattern_type'($urandom_range(0, 3));
      hot_period[b] = $urandom_range(2, 9);
      hot_pos[b]    = 0;
   endtask

   // Mostly trains on recurring branches with patterned outcomes, some predicts
   // ahead of a train, and about a fifth pure noise.
   task automatic queue_branch_mix(input int n);
      int          k, b;
      logic        dir;
      logic [31:0] pc;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) < 2) begin
            queue_req(($urandom_range(0, 1) == 0) ? OP_PREDICT : OP_TRAIN,
                      $urandom, 1'($urandom_range(0, 1)));
         end else begin
            b  = $urandom_range(0, HOT_COUNT - 1);
            pc = ($urandom & 32'hFFFF_F000) | 32'(hot_low[b]);
            case (hot_kind[b])
               LOOP_EXIT: begin
                  dir = (hot_pos[b] != hot_period[b] - 1);
                  hot_pos[b] = (hot_pos[b] + 1) % hot_period[b];
               end
               NEVER_TAKEN: dir = 1'b0;
               ALTERNATING: begin
                  dir = hot_pos[b][0];
                  hot_pos[b]++;
               end
               default: dir = ($urandom_range(0, 7) != 0);
            endcase
            if ($urandom_range(0, 3) == 0) queue_req(OP_PREDICT, pc, 1'($urandom_range(0, 1)));
            queue_req(OP_TRAIN, pc, dir);
         end
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input csr_data_type data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_GLOBAL_HISTORY_BITS: cfg_ghist_bits = data;
         CSR_LOCAL_HISTORY_BITS:  cfg_lhist_bits = data;
         CSR_PC_INDEX_BITS:       cfg_pcidx_bits = data;
         default: ;
      endcase
   endtask

   // Program all three widths; a write to the unused index goes first and must be dropped
   task automatic apply_widths(input csr_data_type g, input csr_data_type l,
                               input csr_data_type p);
      write_csr(CSR_UNUSED_INDEX, csr_data_type'($urandom_range(0, 15)));
      write_csr(CSR_GLOBAL_HISTORY_BITS, g);
      write_csr(CSR_LOCAL_HISTORY_BITS, l);
      write_csr(CSR_PC_INDEX_BITS, p);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Hold until every queued request has gone through and every result is back
   task automatic wait_drained;
      while (pending_reqs.size() != 0 || req_loaded || awaited_dirs.size() != 0)
         @(negedge clock);
   endtask

   // Driver: bursts of transfers with random gaps; hold the payload until taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_dirs.push_back(resolve_branch(cur_req));
            reqs_sent++;
            req_loaded = 1'b0;
         end
         if (!req_loaded) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0) begin
               cur_req    = pending_reqs.pop_front();
               req_loaded = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a zero gap runs bursts back to back
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_valid   <= req_loaded;
         req_opcode  <= cur_req.opcode;
         req_pc      <= cur_req.pc;
         req_outcome <= cur_req.outcome;
      end
   end

   // Receiver: stall in modes of random length, plus one long hold-off so the
   // pipeline fills and the request side backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && reqs_sent >= HOLD_AFTER) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(5, 60);
            end
            mode_left--;
            case (stall_mode)
               0: ready_next = 1'b1;
               1: ready_next = ($urandom_range(0, 3) != 0);
               2: ready_next = ~rsp_ready;
               default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // Monitor: compare each result transfer with the oldest owed prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_dirs.size() == 0) begin
            $display("%0t: unexpected result, prediction %b chose_local %b",
                     $time, rsp_prediction, rsp_chose_local);
            mismatches++;
         end else begin
            seen_dir = awaited_dirs.pop_front();
            if (rsp_prediction !== seen_dir.prediction) begin
               $display("%0t: prediction expected %b actual %b",
                        $time, seen_dir.prediction, rsp_prediction);
               mismatches++;
            end
            if (rsp_chose_local !== seen_dir.chose_local) begin
               $display("%0t: chose_local expected %b actual %b",
                        $time, seen_dir.chose_local, rsp_chose_local);
               mismatches++;
            end
         end
      end
   end

   // Watchdog; covers the clearing pass after reset as well
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, awaited_dirs.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int i, ph;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_opcode   = OP_PREDICT;
      req_pc       = '0;
      req_outcome  = 1'b0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = CSR_GLOBAL_HISTORY_BITS;
      csr_wdata    = '0;
      cur_req      = '0;
      req_loaded   = 1'b0;
      gap_left     = 0;
      burst_left   = 0;
      reqs_sent    = 0;
      mismatches   = 0;
      cycles       = 0;
      hold_left    = 0;
      hold_done    = 1'b0;
      stall_mode   = 0;
      mode_left    = 0;
      ready_next   = 1'b0;

      // model state after reset
      for (i = 0; i < DEPTH; i++) begin
         glob_ctr[i]   = CTR_WEAK_NOT_TAKEN;
         loc_ctr[i]    = CTR_WEAK_NOT_TAKEN;
         choose_ctr[i] = CHOOSER_WEAK_GLOBAL;
         loc_hist[i]   = '0;
      end
      glob_hist      = '0;
      cfg_ghist_bits = GLOBAL_HISTORY_BITS_RST;
      cfg_lhist_bits = LOCAL_HISTORY_BITS_RST;
      cfg_pcidx_bits = PC_INDEX_BITS_RST;
      for (i = 0; i < HOT_COUNT; i++) reroll_hot(i);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: PC extremes, both operations, a predict whose outcome must be
      // ignored, counters driven into both saturation limits, and a PC that
      // aliases PC zero under the reset index width.
      queue_req(OP_PREDICT, 32'h0000_0000, 1'b0);
      queue_req(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
      for (i = 0; i < 3; i++) queue_req(OP_TRAIN, 32'h0000_0000, 1'b1);
      queue_req(OP_PREDICT, 32'h0000_0000, 1'b0);
      for (i = 0; i < 4; i++) queue_req(OP_TRAIN, 32'h0000_0000, 1'b0);
      for (i = 0; i < 4; i++) queue_req(OP_TRAIN, 32'hFFFF_FFFF, i[0] == 1'b0);
      queue_req(OP_PREDICT, 32'hFFFF_FFFF, 1'b0);
      queue_req(OP_TRAIN, 32'h8000_0000, 1'b1);
      queue_req(OP_TRAIN, 32'h7FFF_FFFF, 1'b0);
      queue_req(OP_TRAIN, 32'h0000_0400, 1'b1);
      queue_req(OP_PREDICT, 32'h0000_0000, 1'b1);
      queue_req(OP_TRAIN, 32'hAAAA_AAAA, 1'b1);
      queue_req(OP_TRAIN, 32'h5555_5555, 1'b0);
      queue_branch_mix(150);
      wait_drained;

      // Width phases: zero, above maximum, maximum, minimum, mixed, then random.
      // Tables and histories carry over, so each change runs on trained state.
      for (ph = 0; ph < 10; ph++) begin
         case (ph)
            0: apply_widths(4'd0, 4'd0, 4'd0);
            1: apply_widths(4'd15, 4'd15, 4'd15);
            2: apply_widths(4'd12, 4'd12, 4'd12);
            3: apply_widths(4'd1, 4'd1, 4'd1);
            4: apply_widths(4'd13, 4'd3, 4'd14);
            5: apply_widths(4'd4, 4'd7, 4'd2);
            default: apply_widths(csr_data_type'($urandom_range(0, 15)),
                                  csr_data_type'($urandom_range(0, 15)),
                                  csr_data_type'($urandom_range(0, 15)));
         endcase
         for (i = 0; i < HOT_COUNT; i++) if ($urandom_range(0, 1) == 0) reroll_hot(i);
         queue_branch_mix(85);
         wait_drained;
      end

      // let any stray result show up before the verdict
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/tbp_pkg.sv
rtl/core/tournament_branch_predictor.sv
test/testbench.sv
